@@ rtl/plts_pkg.sv @@
// ----------------------------------------------------------------------------
// plts_pkg
// Shared constants, stack entry type and the controller/datapath links of the
// preemptive LIFO task scheduler.
// ----------------------------------------------------------------------------
package plts_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W     = $clog2(STACK_DEPTH);
  localparam int TASK_ID_W = 8;
  localparam int TIME_W    = 16;
  localparam int DUR_W     = 10;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [DUR_W-1:0]   rem;
  } entry_t;

  typedef struct packed {
    logic load;
    logic pop_arrive;
    logic pop_drain;
    logic update_top;
    logic push;
    logic refuse;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic top_fits;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/plts_task_if.sv @@
// ----------------------------------------------------------------------------
// plts_task_if
// Task channel: arrival or drain command with the arriving task's fields.
// ----------------------------------------------------------------------------
interface plts_task_if import plts_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [TASK_ID_W-1:0] task_id;
  logic [TIME_W-1:0]    start_time;
  logic [DUR_W-1:0]     duration;

  modport source (output valid, command, task_id, start_time, duration, input ready);
  modport sink   (input valid, command, task_id, start_time, duration, output ready);

endinterface

@@ rtl/plts_result_if.sv @@
// ----------------------------------------------------------------------------
// plts_result_if
// Result channel: one completed or refused task per transfer.
// ----------------------------------------------------------------------------
interface plts_result_if import plts_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [TASK_ID_W-1:0] done_id;
  logic [TIME_W-1:0]    finish_time;
  logic                 overflow;
  logic                 last;

  modport source (output valid, done_id, finish_time, overflow, last, input ready);
  modport sink   (input valid, done_id, finish_time, overflow, last, output ready);

endinterface

@@ rtl/plts_ctrl.sv @@
// ----------------------------------------------------------------------------
// plts_ctrl
// Sequencer: accepts a command, steps the pop loop one entry per cycle while
// output is free, then on an arrival charges the top, pushes or refuses it.
// ----------------------------------------------------------------------------
module plts_ctrl import plts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_command_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ARRIVE = 2'd1;
  localparam logic [1:0] S_PUSH   = 2'd2;
  localparam logic [1:0] S_DRAIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_command_i == CMD_DRAIN) ? S_DRAIN : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        if (!status_i.count_zero && status_i.top_fits) begin
          if (status_i.out_free) begin
            cmd_o.pop_arrive = 1'b1;
          end
        end else begin
          cmd_o.update_top = 1'b1;
          state_d          = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!status_i.count_full) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.refuse = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (status_i.count_zero) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.pop_drain = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("plts_ctrl: more than one datapath command");
`endif

endmodule

@@ rtl/plts_dp.sv @@
// ----------------------------------------------------------------------------
// plts_dp
// Datapath: task stack memory with registered top and next-to-top reads,
// stack count, current minute, span, and the result register.
// ----------------------------------------------------------------------------
module plts_dp import plts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic [TASK_ID_W-1:0] task_id_i,
  input  logic [TIME_W-1:0]    start_time_i,
  input  logic [DUR_W-1:0]     duration_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [TASK_ID_W-1:0] done_id_o,
  output logic [TIME_W-1:0]    finish_time_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  entry_t             mem_q [STACK_DEPTH];
  entry_t             top_q, next_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  span_q, span_d;
  logic [TIME_W-1:0]  start_q;
  logic [ID_BITS-1:0] id_q;
  logic [DUR_W-1:0]   dur_q;

  logic               out_valid_q, out_valid_d;
  logic [TASK_ID_W-1:0] out_id_q, out_id_d;
  logic [TIME_W-1:0]  out_time_q, out_time_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_last_q, out_last_d;
  logic               emit;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [CNT_W-1:0]   top_cnt, next_cnt, new_top_cnt;
  logic [IDX_W-1:0]   next_addr, rd_addr;

  logic [TIME_W-1:0]  top_rem;
  logic [TIME_W-1:0]  span_left;
  logic [TIME_W:0]    now_sum;
  logic [TIME_W-1:0]  drain_time;
  logic               count_one;

  assign top_rem    = TIME_W'(top_q.rem);
  assign span_left  = span_q - top_rem;
  assign now_sum    = {1'b0, now_q} + (TIME_W + 1)'(top_q.rem);
  assign drain_time = now_sum[TIME_W] ? TIME_MAX : now_sum[TIME_W-1:0];
  assign count_one  = (count_q == CNT_W'(1));

  assign status_o.count_zero = (count_q == '0);
  assign status_o.count_full = (count_q == CNT_W'(STACK_DEPTH));
  assign status_o.top_fits   = (top_rem <= span_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign emit = cmd_i.pop_arrive || cmd_i.pop_drain || cmd_i.refuse;

  always_comb begin
    count_d    = count_q;
    now_d      = now_q;
    span_d     = span_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[IDX_W-1:0];
    wr_data    = top_q;
    out_id_d   = out_id_q;
    out_time_d = out_time_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;

    if (cmd_i.load) begin
      span_d = (start_time_i >= now_q) ? (start_time_i - now_q) : '0;
    end

    if (cmd_i.pop_arrive) begin
      span_d     = span_left;
      now_d      = now_sum[TIME_W-1:0];
      count_d    = count_q - CNT_W'(1);
      out_id_d   = TASK_ID_W'(top_q.id);
      out_time_d = now_sum[TIME_W-1:0];
      out_ovf_d  = 1'b0;
      out_last_d = count_one || (TIME_W'(next_q.rem) > span_left);
    end

    if (cmd_i.pop_drain) begin
      now_d      = drain_time;
      count_d    = count_q - CNT_W'(1);
      out_id_d   = TASK_ID_W'(top_q.id);
      out_time_d = drain_time;
      out_ovf_d  = 1'b0;
      out_last_d = count_one;
    end

    if (cmd_i.update_top) begin
      // charge the surviving top with the rest of the span
      wr_en       = !status_o.count_zero;
      wr_addr     = top_cnt[IDX_W-1:0];
      wr_data.id  = top_q.id;
      wr_data.rem = top_q.rem - DUR_W'(span_q);
      now_d       = (start_q > now_q) ? start_q : now_q;
    end

    if (cmd_i.push) begin
      wr_en       = 1'b1;
      wr_addr     = count_q[IDX_W-1:0];
      wr_data.id  = id_q;
      wr_data.rem = dur_q;
      count_d     = count_q + CNT_W'(1);
    end

    if (cmd_i.refuse) begin
      out_id_d   = TASK_ID_W'(id_q);
      out_time_d = '0;
      out_ovf_d  = 1'b1;
      out_last_d = 1'b1;
    end
  end

  assign top_cnt     = count_q - CNT_W'(1);
  assign next_cnt    = count_d - CNT_W'(2);
  assign new_top_cnt = count_d - CNT_W'(1);
  assign next_addr   = next_cnt[IDX_W-1:0];
  assign rd_addr     = new_top_cnt[IDX_W-1:0];

  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    top_q  <= (wr_en && (wr_addr == rd_addr))   ? wr_data : mem_q[rd_addr];
    next_q <= (wr_en && (wr_addr == next_addr)) ? wr_data : mem_q[next_addr];
  end

  always_ff @(posedge clk_i) begin
    span_q     <= span_d;
    out_id_q   <= out_id_d;
    out_time_q <= out_time_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
    if (cmd_i.load) begin
      start_q <= start_time_i;
      id_q    <= ID_BITS'(task_id_i);
      dur_q   <= duration_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign done_id_o     = out_id_q;
  assign finish_time_o = out_time_q;
  assign overflow_o    = out_ovf_q;
  assign last_o        = out_last_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("plts_dp: stack count beyond depth");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("plts_dp: result overwrites an untaken transfer");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_arrive || cmd_i.pop_drain) |-> (count_q != '0))
    else $error("plts_dp: pop from empty stack");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CNT_W'(STACK_DEPTH)))
    else $error("plts_dp: push onto full stack");
  a_now_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (now_q >= $past(now_q)))
    else $error("plts_dp: current minute went backwards");
`endif

endmodule

@@ rtl/preemptive_lifo_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// preemptive_lifo_task_scheduler
// Preemptive LIFO task scheduler.
//
// task_i carries an arrival (command 0: id, start minute, duration) or a
// drain (command 1). result_o carries one transfer per completed task with
// its finish minute, or one per refused arrival with overflow set; last marks
// the final result of a command.
// An arrival completes P stacked tasks (up to 16): the pop loop retires one
// stack entry per cycle while the output register is free, then the ARRIVE
// state charges the surviving top and the PUSH state pushes or refuses the
// new task. A drain pops all N stacked tasks before returning to idle.
// Each result waits in an output register; a stalled receiver holds the pop
// loop at that result, and the next command is taken only after the last
// result of the current one has been registered.
// Reset clears the stack count, the current minute and the output valid;
// stack contents are never used before being written.
// ----------------------------------------------------------------------------
module preemptive_lifo_task_scheduler import plts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  plts_task_if.sink     task_i,
  plts_result_if.source result_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  plts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (task_i.valid),
    .in_command_i (task_i.command),
    .in_ready_o   (task_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  plts_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .task_id_i     (task_i.task_id),
    .start_time_i  (task_i.start_time),
    .duration_i    (task_i.duration),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .done_id_o     (result_o.done_id),
    .finish_time_o (result_o.finish_time),
    .overflow_o    (result_o.overflow),
    .last_o        (result_o.last)
  );

endmodule
